>>> hw/rtl/fcsg_pkg.sv
// shared types and constants for the filled circle span generator
`default_nettype none

package fcsg_pkg;

    localparam int RAD_W   = 5;
    localparam int COORD_W = 16;
    localparam int COLOR_W = 16;
    localparam int LEN_W   = 6;
    localparam int SQ_W    = 10;
    localparam int PROD_W  = 13;

    // 181/256 stands in for 707/1000; the floor matches for every 5-bit radius
    localparam logic [7:0] IMAX_RECIP = 8'd181;
    localparam int         IMAX_SHIFT = 8;

    // one circle job as it travels from the front to the walker
    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COLOR_W-1:0] color;
        logic [RAD_W-1:0]   r;
        logic [RAD_W-1:0]   imax;
        logic [SQ_W-1:0]    rsq;
        logic [SQ_W-1:0]    sqmax;
    } t_job;

    // one span beat
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [LEN_W-1:0]   len;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_span;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CENTER,
        S_OUT_POS,
        S_OUT_NEG,
        S_IN_POS,
        S_IN_NEG
    } t_back_state;

endpackage

`default_nettype wire

>>> hw/rtl/fcsg_fifo.sv
// small register queue used between stages
`default_nettype none

module fcsg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> hw/rtl/fcsg_front.sv
// request front: accepts circles, clamps radius, precomputes walk bounds
`default_nettype none

module fcsg_front
    import fcsg_pkg::*;
#(
    parameter int MAX_RADIUS = 31
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire logic [COORD_W-1:0] i_center_x,
    input  wire logic [COORD_W-1:0] i_center_y,
    input  wire logic [RAD_W-1:0]   i_radius,
    input  wire logic [COLOR_W-1:0] i_fill_color,
    output logic                    o_job_push,
    output t_job                    o_job,
    input  wire logic               i_job_full
);

    localparam logic [RAD_W-1:0] MAX_R = RAD_W'(MAX_RADIUS);

    logic                r_valid;
    t_job                r_job;
    t_job                n_job;
    logic [RAD_W-1:0]    rad_clamp;
    logic [PROD_W-1:0]   prod;
    logic [SQ_W-1:0]     rsq;
    logic                accept;
    logic                drain;

    // clamp and derive imax, r*r and the distance threshold
    always_comb begin
        rad_clamp   = (i_radius > MAX_R) ? MAX_R : i_radius;
        prod        = PROD_W'(rad_clamp) * PROD_W'(IMAX_RECIP);
        rsq         = SQ_W'(rad_clamp) * SQ_W'(rad_clamp);
        n_job.cx    = i_center_x;
        n_job.cy    = i_center_y;
        n_job.color = i_fill_color;
        n_job.r     = rad_clamp;
        n_job.imax  = prod[IMAX_SHIFT +: RAD_W] + RAD_W'(1);
        n_job.rsq   = rsq;
        n_job.sqmax = rsq + SQ_W'(rad_clamp >> 1);
    end

    assign drain      = r_valid && !i_job_full;
    assign o_full     = r_valid && i_job_full;
    assign accept     = i_push && !o_full;
    assign o_job_push = r_valid;
    assign o_job      = r_job;

    // classify: a zero radius is dropped here and never reaches the walker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= (rad_clamp != '0);
        end else if (drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

    a_no_zero_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_job.r != '0 && r_job.imax != '0))
        else $error("zero radius job held in front stage");

endmodule

`default_nettype wire

>>> hw/rtl/fcsg_back.sv
// span walker: steps the circle outline and emits spans one beat at a time
`default_nettype none

module fcsg_back
    import fcsg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_empty,
    input  wire t_job i_job,
    output logic      o_job_pop,
    output logic      o_span_push,
    output t_span     o_span,
    input  wire logic i_span_full
);

    t_back_state        r_state;
    t_back_state        n_state;
    t_job               r_job;
    logic [RAD_W-1:0]   r_x;
    logic [RAD_W-1:0]   r_i;
    logic [SQ_W-1:0]    r_isq;
    logic [SQ_W-1:0]    r_xsq;

    // pending span, held until the next one shows up or the circle ends
    logic               r_pend_valid;
    logic               r_pend_last;
    t_span              r_pend;

    t_span              cand;
    logic               cand_v;
    logic               take;
    logic               push;
    logic               adv;
    logic               fin;
    logic               cond;
    logic               outer;
    logic               dec_x;
    logic               step_i;
    logic [RAD_W-1:0]   im1;
    logic [SQ_W:0]      sum_sq;

    assign im1    = r_i - RAD_W'(1);
    assign sum_sq = {1'b0, r_isq} + {1'b0, r_xsq};
    assign cond   = sum_sq > {1'b0, r_job.sqmax};
    assign outer  = cond && (r_x > r_job.imax);

    // hand-off between walker, pending span and output queue
    assign push   = r_pend_valid && !i_span_full && (r_pend_last || cand_v);
    assign take   = cand_v && (!r_pend_valid || push);
    assign adv    = !cand_v || take;
    assign fin    = (r_state == S_IN_NEG) && (r_i == r_job.imax);
    assign dec_x  = adv && (r_x != '0) &&
                    (((r_state == S_OUT_POS) && !outer && cond) || (r_state == S_OUT_NEG));
    assign step_i = adv && (r_state == S_IN_NEG) && !fin;

    assign o_span_push = push;
    always_comb begin
        o_span      = r_pend;
        o_span.last = r_pend_last;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_job_empty) n_state = S_CENTER;
            end
            S_CENTER: begin
                if (adv) n_state = S_OUT_POS;
            end
            S_OUT_POS: begin
                if (adv) n_state = outer ? S_OUT_NEG : S_IN_POS;
            end
            S_OUT_NEG: begin
                if (adv) n_state = S_IN_POS;
            end
            S_IN_POS: begin
                if (adv) n_state = S_IN_NEG;
            end
            S_IN_NEG: begin
                if (adv) n_state = fin ? S_IDLE : S_OUT_POS;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // candidate span for the current step
    always_comb begin
        o_job_pop  = 1'b0;
        cand_v     = 1'b0;
        cand.x     = r_job.cx - COORD_W'(r_x);
        cand.y     = r_job.cy;
        cand.len   = {r_x, 1'b0};
        cand.color = r_job.color;
        cand.last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_job_pop = !i_job_empty;
            end
            S_CENTER: begin
                cand_v   = 1'b1;
                cand.x   = r_job.cx - COORD_W'(r_job.r);
                cand.len = {r_job.r, 1'b0};
            end
            S_OUT_POS: begin
                cand_v   = outer && (im1 != '0);
                cand.x   = r_job.cx - COORD_W'(im1);
                cand.y   = r_job.cy + COORD_W'(r_x);
                cand.len = {im1, 1'b0};
            end
            S_OUT_NEG: begin
                cand_v   = (im1 != '0);
                cand.x   = r_job.cx - COORD_W'(im1);
                cand.y   = r_job.cy - COORD_W'(r_x);
                cand.len = {im1, 1'b0};
            end
            S_IN_POS: begin
                cand_v = (r_x != '0);
                cand.y = r_job.cy + COORD_W'(r_i);
            end
            S_IN_NEG: begin
                cand_v = (r_x != '0);
                cand.y = r_job.cy - COORD_W'(r_i);
            end
            default: begin
                cand_v = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // walk registers: x shrinks on the outline, i climbs row by row
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
            r_x   <= i_job.r;
            r_xsq <= i_job.rsq;
            r_i   <= RAD_W'(1);
            r_isq <= SQ_W'(1);
        end else begin
            if (dec_x) begin
                r_x   <= r_x - RAD_W'(1);
                r_xsq <= r_xsq - {{(SQ_W-RAD_W-1){1'b0}}, r_x, 1'b0} + SQ_W'(1);
            end
            if (step_i) begin
                r_i   <= r_i + RAD_W'(1);
                r_isq <= r_isq + {{(SQ_W-RAD_W-1){1'b0}}, r_i, 1'b0} + SQ_W'(1);
            end
        end
    end

    // pending span control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_last  <= 1'b0;
        end else if (take) begin
            r_pend_valid <= 1'b1;
            r_pend_last  <= fin;
        end else if (push) begin
            r_pend_valid <= 1'b0;
            r_pend_last  <= 1'b0;
        end else if (fin && adv) begin
            r_pend_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pend <= cand;
        end
    end

    a_last_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_last |-> r_pend_valid)
        else $error("last flag set with no pending span");

    a_final_has_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin && adv && !cand_v) |-> r_pend_valid)
        else $error("circle ended with no span to flag");

    a_nonzero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (cand.len != '0))
        else $error("zero length span taken");

endmodule

`default_nettype wire

>>> hw/rtl/filled_circle_span_generator_core.sv
// filled circle span generator top level: front, job queue, walker, span queue
// Usage:
//   Requests enter through a queue-style port: a beat of center, radius and
//   color is taken when push is high and full is low. Spans leave through a
//   queue-style port: while empty is low the oldest span is on o_span_*, and
//   it is taken when pop is high. The last span of a circle has o_last_span.
//   A zero radius gives no spans at all; a radius above MAX_RADIUS is clamped.
// Flow:
//   The front registers a request and hands it to a two-entry job queue,
//   so up to three requests wait while the walker is busy with an earlier
//   circle. The walker pops a job, emits the center row, then steps rows
//   through S_OUT_POS, S_OUT_NEG when the step adds an outer pair, S_IN_POS
//   and S_IN_NEG, over imax = r*0.707+1 steps: at most 63 spans for r = 31.
//   The walk, not the span port, sets the throughput. The first span passes
//   the front register, job queue, walker pending register and span queue;
//   for a radius of one it waits in the pending register until the walk ends.
// Reset and stalls:
//   Synchronous active-low reset empties both queues and returns the walker
//   to idle. When the receiver holds pop low the span queue fills, the walker
//   stops where it is, then the job queue fills and full rises.
`default_nettype none

module filled_circle_span_generator_core
    import fcsg_pkg::*;
#(
    parameter int MAX_RADIUS = 31
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [COORD_W-1:0] i_center_x,
    input  wire logic [COORD_W-1:0] i_center_y,
    input  wire logic [RAD_W-1:0]   i_radius,
    input  wire logic [COLOR_W-1:0] i_fill_color,
    output logic                    empty,
    input  wire logic               pop,
    output logic [COORD_W-1:0]      o_span_x,
    output logic [COORD_W-1:0]      o_span_y,
    output logic [LEN_W-1:0]        o_span_len,
    output logic [COLOR_W-1:0]      o_span_color,
    output logic                    o_last_span
);

    localparam int JOB_W  = $bits(t_job);
    localparam int SPAN_W = $bits(t_span);

    logic             job_push;
    t_job             job_in;
    logic             job_full;
    logic [JOB_W-1:0] job_q;
    logic             job_empty;
    logic             job_pop;
    logic             span_push;
    t_span            span_in;
    logic             span_full;
    logic [SPAN_W-1:0] span_q;
    t_span            span_out;

    fcsg_front #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_radius     (i_radius),
        .i_fill_color (i_fill_color),
        .o_job_push   (job_push),
        .o_job        (job_in),
        .i_job_full   (job_full)
    );

    // job queue between front and walker
    fcsg_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_wdata (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_rdata (job_q),
        .o_empty (job_empty)
    );

    fcsg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (t_job'(job_q)),
        .o_job_pop   (job_pop),
        .o_span_push (span_push),
        .o_span      (span_in),
        .i_span_full (span_full)
    );

    // span queue toward the receiver
    fcsg_fifo #(
        .WIDTH (SPAN_W),
        .DEPTH (2)
    ) u_span_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (span_push),
        .i_wdata (span_in),
        .o_full  (span_full),
        .i_pop   (pop),
        .o_rdata (span_q),
        .o_empty (empty)
    );

    assign span_out     = t_span'(span_q);
    assign o_span_x     = span_out.x;
    assign o_span_y     = span_out.y;
    assign o_span_len   = span_out.len;
    assign o_span_color = span_out.color;
    assign o_last_span  = span_out.last;

endmodule

`default_nettype wire

>>> tb/sv/filled_circle_span_checker.sv
// span checker: watches both queue ports, predicts the spans and compares them
module filled_circle_span_checker
    import fcsg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic               i_full,
    input  wire logic [COORD_W-1:0] i_center_x,
    input  wire logic [COORD_W-1:0] i_center_y,
    input  wire logic [RAD_W-1:0]   i_radius,
    input  wire logic [COLOR_W-1:0] i_fill_color,
    input  wire logic               i_empty,
    input  wire logic               i_pop,
    input  wire logic [COORD_W-1:0] i_span_x,
    input  wire logic [COORD_W-1:0] i_span_y,
    input  wire logic [LEN_W-1:0]   i_span_len,
    input  wire logic [COLOR_W-1:0] i_span_color,
    input  wire logic               i_last_span,
    output int                      o_errors,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CIRCLE_MAX_RADIUS = 31;
    localparam int CIRCLE_MAX_SPANS  = 64;

    t_span circle_spans[$];
    t_span expected_spans[$];

    initial o_errors = 0;
    initial o_pending = 0;

    // queue one span of the circle being rasterized, empty spans and any beyond CIRCLE_MAX_SPANS are dropped
    function automatic void stage_span(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                                       int len, logic [COLOR_W-1:0] col);
        t_span s;
        if (len == 0 || circle_spans.size() >= CIRCLE_MAX_SPANS)
            return;
        s.x     = sx;
        s.y     = sy;
        s.len   = LEN_W'(len);
        s.color = col;
        s.last  = 1'b0;
        circle_spans.push_back(s);
    endfunction

    // walk the circle outline and append its spans to the expected spans
    function automatic void rasterize_circle(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                             logic [RAD_W-1:0] rad, logic [COLOR_W-1:0] col);
        int r;
        int imax;
        int sqmax;
        int xw;
        circle_spans.delete();
        r = int'(rad);
        if (r > CIRCLE_MAX_RADIUS)
            r = CIRCLE_MAX_RADIUS;
        if (r == 0)
            return;
        imax  = r * 707 / 1000 + 1;
        sqmax = r * r + r / 2;
        xw    = r;
        // center row
        stage_span(COORD_W'(int'(cx) - r), cy, 2 * r, col);
        for (int i = 1; i <= imax; i++) begin
            if (i * i + xw * xw > sqmax) begin
                // outer rows while the walk is still above the diagonal
                if (xw > imax) begin
                    stage_span(COORD_W'(int'(cx) - i + 1), COORD_W'(int'(cy) + xw),
                               2 * (i - 1), col);
                    stage_span(COORD_W'(int'(cx) - i + 1), COORD_W'(int'(cy) - xw),
                               2 * (i - 1), col);
                end
                if (xw > 0)
                    xw--;
            end
            // inner rows
            stage_span(COORD_W'(int'(cx) - xw), COORD_W'(int'(cy) + i), 2 * xw, col);
            stage_span(COORD_W'(int'(cx) - xw), COORD_W'(int'(cy) - i), 2 * xw, col);
        end
        if (circle_spans.size() > 0)
            circle_spans[$].last = 1'b1;
        foreach (circle_spans[k])
            expected_spans.push_back(circle_spans[k]);
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            o_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // compare each span beat against the oldest expected span
    always @(posedge i_clk) begin
        t_span want;
        if (i_rst_n && i_pop && !i_empty) begin
            if (expected_spans.size() == 0) begin
                o_errors++;
                $display("%0t: unexpected span beat, expected none, actual x=%0d y=%0d len=%0d",
                         $time, i_span_x, i_span_y, i_span_len);
            end else begin
                want = expected_spans.pop_front();
                check_field("span_x", want.x, i_span_x);
                check_field("span_y", want.y, i_span_y);
                check_field("span_len", want.len, i_span_len);
                check_field("span_color", want.color, i_span_color);
                check_field("last_span", want.last, i_last_span);
            end
        end
        if (i_rst_n && i_push && !i_full)
            rasterize_circle(i_center_x, i_center_y, i_radius, i_fill_color);
        o_pending = expected_spans.size();
    end

endmodule

>>> tb/sv/filled_circle_span_generator_core_test.sv
// testbench top: drives circle requests and span pops, gives the verdict
module filled_circle_span_generator_core_test
    import fcsg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLDOFF_CYCLES = 600;
    localparam int ITEMS_PER_PHASE = 75;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [COORD_W-1:0] center_x = '0;
    logic [COORD_W-1:0] center_y = '0;
    logic [RAD_W-1:0]   radius = '0;
    logic [COLOR_W-1:0] fill_color = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [COORD_W-1:0] span_x;
    logic [COORD_W-1:0] span_y;
    logic [LEN_W-1:0]   span_len;
    logic [COLOR_W-1:0] span_color;
    logic               last_span;

    int error_count;
    int spans_pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int holdoff_requests = 0;
    int holdoffs_done = 0;
    int hold_left = 0;

    filled_circle_span_generator_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_center_x   (center_x),
        .i_center_y   (center_y),
        .i_radius     (radius),
        .i_fill_color (fill_color),
        .empty        (empty),
        .pop          (pop),
        .o_span_x     (span_x),
        .o_span_y     (span_y),
        .o_span_len   (span_len),
        .o_span_color (span_color),
        .o_last_span  (last_span)
    );

    filled_circle_span_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_center_x   (center_x),
        .i_center_y   (center_y),
        .i_radius     (radius),
        .i_fill_color (fill_color),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_span_x     (span_x),
        .i_span_y     (span_y),
        .i_span_len   (span_len),
        .i_span_color (span_color),
        .i_last_span  (last_span),
        .o_errors     (error_count),
        .o_pending    (spans_pending)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // span receiver: random stalls plus requested long holdoffs
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holdoff_requests != holdoffs_done) begin
            pop <= 1'b0;
            hold_left <= HOLDOFF_CYCLES;
            holdoffs_done <= holdoffs_done + 1;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one circle request beat, called and returning at a falling edge
    task automatic send_circle(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                               input logic [RAD_W-1:0] r, input logic [COLOR_W-1:0] col);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push       <= 1'b1;
        center_x   <= cx;
        center_y   <= cy;
        radius     <= r;
        fill_color <= col;
        do
            @(posedge i_clk);
        while (full);
        @(negedge i_clk);
    endtask

    // coordinates favor the plane edges so that wrapping is exercised
    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(3))
            0: return COORD_W'($urandom_range(40));
            1: return COORD_W'(65535 - $urandom_range(40));
            default: return COORD_W'($urandom);
        endcase
    endfunction

    initial begin
        int wait_cycles;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zero radius, smallest and largest radii, plane corners
        send_circle(16'd100, 16'd100, 5'd0, 16'h1234);
        send_circle(16'd0, 16'd0, 5'd1, 16'h0000);
        send_circle(16'hFFFF, 16'hFFFF, 5'd2, 16'hFFFF);
        send_circle(16'd0, 16'd0, 5'd31, 16'hA5A5);
        send_circle(16'hFFFF, 16'hFFFF, 5'd31, 16'h5A5A);
        send_circle(16'd10, 16'hFFFA, 5'd31, 16'h0001);
        send_circle(16'hFFFF, 16'd0, 5'd0, 16'h8000);
        send_circle(16'd0, 16'hFFFF, 5'd1, 16'h7FFF);
        for (int r = 3; r <= 8; r++)
            send_circle(16'd1000, 16'd1000, RAD_W'(r), 16'(r * 4099));
        send_circle(16'd32768, 16'd32767, 5'd16, 16'hF00F);
        send_circle(16'd20, 16'd65520, 5'd30, 16'h0FF0);
        send_circle(16'd5, 16'd5, 5'd29, 16'h3C3C);

        // random phases: receiver holdoff, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    holdoff_requests++;
                end
                1: begin
                    send_idle_pct  = 65;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 65;
                end
                default: begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 27;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_circle(pick_coord(), pick_coord(), RAD_W'($urandom_range(31)),
                            COLOR_W'($urandom));
        end
        push <= 1'b0;

        // drain, then leave room for spans nobody asked for
        while (spans_pending != 0)
            @(posedge i_clk);
        wait_cycles = 0;
        while (wait_cycles < 200) begin
            @(posedge i_clk);
            wait_cycles++;
        end

        if (error_count == 0 && spans_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
